@@ design/sitda_pkg.sv @@
// sitda_pkg: shared types and constants for the signed integer to decimal ascii block
// no dependencies; imported by every module of the block

package sitda_pkg;

    // width of the magnitude and the input value
    localparam int unsigned MAG_W = 32;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // reciprocal of ten: q = (x * RECIP_10) >> RECIP_SHIFT is exact for 32-bit x
    localparam logic [MAG_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int unsigned      RECIP_SHIFT = 35;
    localparam int unsigned      QUOT_W      = 2 * MAG_W - RECIP_SHIFT;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIG,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

@@ design/sitda_if.sv @@
// sitda_in_if / sitda_out_if: valid-ready channels of the block
// depends on sitda_pkg for widths

interface sitda_in_if;
    import sitda_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [MAG_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last;

    modport source (output valid, output text_char, output last, input ready);
    modport sink   (input valid, input text_char, input last, output ready);
endinterface

@@ design/sitda_div10.sv @@
// sitda_div10: shared divide-by-ten unit, reciprocal multiply then remainder
// depends on sitda_pkg; quotient registered on load

module sitda_div10 (
    input  logic                      clk,
    input  logic                      load,
    input  logic [sitda_pkg::MAG_W-1:0] dividend,
    output logic [sitda_pkg::MAG_W-1:0] quot,
    output logic [3:0]                rem
);
    import sitda_pkg::*;

    logic [2*MAG_W-1:0] product;
    logic [MAG_W-1:0]   quot_reg;
    logic [MAG_W-1:0]   quot_times10;
    logic [MAG_W-1:0]   diff;

    // reciprocal multiply
    assign product = dividend * RECIP_10;

    // quotient register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quot_reg <= MAG_W'(product[2*MAG_W-1:RECIP_SHIFT]);
        end
    end

    // remainder from the held dividend: x - 10 * q
    assign quot_times10 = {quot_reg[MAG_W-4:0], 3'b000} + {quot_reg[MAG_W-2:0], 1'b0};
    assign diff         = dividend - quot_times10;

    assign quot = quot_reg;
    assign rem  = diff[3:0];

endmodule

@@ design/signed_int_to_decimal_ascii.sv @@
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ascii characters
// depends on sitda_pkg, sitda_if (sitda_in_if, sitda_out_if) and sitda_div10
//
//   channel | dir | fields           | request
//   din     | in  | value[31:0] s    | one integer to convert
//   dout    | out | text_char, last  | one character, last on the final one
//
// a request is split into D digits by one reciprocal multiply step and one remainder
// step per digit in the shared divide unit, then its characters go out one per
// cycle while dout is not stalled.
// din is ready only while the sequencer is idle; dout has an output register, so
// the final character may still wait while the next request is taken.
// reset clears the sequencer and the output valid; the digit store needs no reset.

module signed_int_to_decimal_ascii #(
    parameter int MAX_DIGITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    sitda_in_if.sink    din,
    sitda_out_if.source dout
);
    import sitda_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    state_t           state_reg, state_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             neg_reg, neg_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;

    logic [3:0]       digit_store [MAX_DIGITS];
    logic             store_we;
    logic [CNT_W-1:0] rd_cnt;
    logic [3:0]       rd_digit;

    logic             div_load;
    logic [MAG_W-1:0] div_quot;
    logic [3:0]       div_rem;
    logic [MAG_W-1:0] raw;
    logic             slot_free;

    // shared divide-by-ten unit
    sitda_div10 u_div10 (
        .clk      (clk),
        .load     (div_load),
        .dividend (mag_reg),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign raw       = MAG_W'(din.value);
    assign slot_free = !out_valid_reg || dout.ready;
    assign rd_cnt    = count_reg - CNT_W'(1);
    assign rd_digit  = digit_store[rd_cnt[IDX_W-1:0]];

    // sequencer state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // magnitude and output payload
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // digit store, least significant digit first
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            digit_store[count_reg[IDX_W-1:0]] <= div_rem;
        end
    end

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        count_next     = count_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        store_we       = 1'b0;
        div_load       = 1'b0;
        din.ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                din.ready = 1'b1;
                if (din.valid)
                begin
                    neg_next   = raw[MAG_W-1];
                    mag_next   = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;
                    count_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_load   = 1'b1;
                state_next = ST_DIG;
            end
            ST_DIG:
            begin
                store_we   = 1'b1;
                mag_next   = div_quot;
                count_next = count_reg + CNT_W'(1);
                if (div_quot != '0 && count_reg < CNT_W'(MAX_DIGITS - 1))
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + {4'b0000, rd_digit};
                    out_last_next  = (count_reg == CNT_W'(1));
                    count_next     = rd_cnt;
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign dout.valid     = out_valid_reg;
    assign dout.text_char = out_char_reg;
    assign dout.last      = out_last_reg;

    // the final character of a number is always a digit
    assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && dout.last |-> dout.text_char != CHAR_MINUS)
        else $error("last flag on a minus sign");

    // digit count never exceeds the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    // a remainder step always follows a multiply step
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIG |-> $past(state_reg) == ST_MUL)
        else $error("digit step without multiply");

    // an accepted request starts the split
    assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready |=> state_reg == ST_MUL && count_reg == '0)
        else $error("request not started");

endmodule

@@ tb/sv/signed_int_to_decimal_ascii_tb.sv @@
// signed_int_to_decimal_ascii_tb: checks the decimal text of every request against a predictor
// depends on sitda_pkg, sitda_if (sitda_in_if, sitda_out_if) and signed_int_to_decimal_ascii
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;
    import sitda_pkg::*;

    localparam int MAX_DIGITS  = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
    } text_item_t;

    // expected decimal text of every accepted request, one entry per character
    class decimal_text_checker;
        int unsigned      max_digits;
        logic [32:0]      remaining_mag;
        logic [3:0]       digit_store [20];
        int unsigned      digit_count;
        logic             negative;
        text_item_t       expected_chars [$];
        int unsigned      numbers_seen;
        int unsigned      negatives_seen;
        int unsigned      chars_checked;
        int unsigned      mismatches;

        function new(int unsigned digits);
            max_digits     = digits;
            remaining_mag  = '0;
            digit_count    = 0;
            negative       = 1'b0;
            numbers_seen   = 0;
            negatives_seen = 0;
            chars_checked  = 0;
            mismatches     = 0;
        endfunction

        // split one accepted value into its characters
        function void add_number(logic signed [MAG_W-1:0] value);
            text_item_t item;
            negative      = value[MAG_W-1];
            remaining_mag = negative ? 33'd0 - {value[MAG_W-1], value} : {1'b0, value};
            digit_count   = 0;
            do begin
                digit_store[digit_count] = 4'(remaining_mag % 10);
                digit_count++;
                remaining_mag = remaining_mag / 10;
            end while (remaining_mag != 0 && digit_count < max_digits);
            if (negative)
            begin
                item.text_char = CHAR_MINUS;
                item.last      = 1'b0;
                expected_chars.push_back(item);
                negatives_seen++;
            end
            for (int k = digit_count; k > 0; k--)
            begin
                item.text_char = CHAR_ZERO + 8'(digit_store[k-1]);
                item.last      = (k == 1);
                expected_chars.push_back(item);
            end
            numbers_seen++;
        endfunction

        // compare one output character with the oldest expected one
        function void check_char(logic [7:0] text_char, logic last);
            text_item_t want;
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character: text_char %h last %b", text_char, last);
                mismatches++;
                return;
            end
            want = expected_chars.pop_front();
            if (text_char !== want.text_char)
            begin
                $error("text_char: expected %h, actual %h", want.text_char, text_char);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %b, actual %b", want.last, last);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sitda_in_if  din_if ();
    sitda_out_if dout_if ();

    decimal_text_checker text_chk;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    logic        hold_toggle;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    signed_int_to_decimal_ascii #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen     <= hold_toggle;
            hold_left     <= HOLD_CYCLES;
            dout_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            dout_if.ready <= 1'b0;
        end
        else
        begin
            dout_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid === 1'b1 && dout_if.ready === 1'b1)
            text_chk.check_char(dout_if.text_char, dout_if.last);
    end

    function automatic longint unsigned pow10(int unsigned n);
        longint unsigned p;
        p = 1;
        repeat (n) p = p * 10;
        return p;
    endfunction

    // mostly values of a random digit count, some near powers of ten, some raw bits
    function automatic logic signed [MAG_W-1:0] random_value();
        int unsigned     pick;
        int unsigned     d;
        logic            neg;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mag;
        logic [MAG_W-1:0] m32;
        pick = $urandom_range(0, 9);
        neg  = 1'($urandom_range(0, 1));
        if (pick >= 7)
            return $urandom;
        if (pick == 6)
        begin
            d   = $urandom_range(1, 9);
            mag = pow10(d) - 1 + $urandom_range(0, 2);
        end
        else
        begin
            d  = $urandom_range(1, 10);
            lo = (d == 1) ? 0 : pow10(d - 1);
            hi = pow10(d) - 1;
            if (hi > 64'd2147483648)
                hi = 64'd2147483648;
            mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
        end
        if (!neg && mag > 64'd2147483647)
            mag = 64'd2147483647;
        m32 = 32'(mag);
        return neg ? -m32 : m32;
    endfunction

    // offer one request, with random gaps before it
    task automatic send_number(input logic signed [MAG_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            din_if.valid <= 1'b0;
            @(posedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.value <= value;
        do @(posedge clk); while (din_if.ready !== 1'b1);
        text_chk.add_number(value);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_number(random_value());
    endtask

    // stop offering until every expected character has come out
    task automatic wait_for_text();
        din_if.valid <= 1'b0;
        @(posedge clk);
        while (text_chk.pending() != 0) @(posedge clk);
    endtask

    // directed values: zero, extremes, digit boundaries, every digit
    logic signed [MAG_W-1:0] corner_values [] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
        -32'sd100, 32'sd999999999, 32'sd1000000000, -32'sd1000000000,
        32'sd2147483647, -32'sd2147483647, 32'sh8000_0000, 32'sd1234567890,
        -32'sd1234567890, 32'sd7, -32'sd2147483640
    };

    // stimulus
    initial
    begin
        text_chk      = new(MAX_DIGITS);
        rst_n         = 1'b0;
        tx_idle_pct   = 17;
        rx_idle_pct   <= 69;
        hold_toggle   <= 1'b0;
        din_if.valid  <= 1'b0;
        din_if.value  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles a little, receiver a lot
        foreach (corner_values[i])
            send_number(corner_values[i]);
        send_random(100);

        // long receiver hold-off while requests keep coming
        tx_idle_pct = 0;
        hold_toggle <= ~hold_toggle;
        send_random(20);
        wait_for_text();

        // sender idles a lot, receiver a little
        tx_idle_pct = 69;
        rx_idle_pct <= 17;
        send_random(100);
        wait_for_text();

        // no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        send_random(100);
        wait_for_text();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (text_chk.pending() != 0)
        begin
            $error("%0d expected characters never arrived", text_chk.pending());
            text_chk.mismatches++;
        end

        $display("converted %0d numbers (%0d negative, incl. zero and both extremes)",
                 text_chk.numbers_seen, text_chk.negatives_seen);
        $display("checked %0d characters under mixed and long back-pressure, %0d mismatches",
                 text_chk.chars_checked, text_chk.mismatches);
        if (text_chk.mismatches == 0)
            $display("** signed_int_to_decimal_ascii: PASSED **");
        else
            $display("** signed_int_to_decimal_ascii: FAILED **");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("** signed_int_to_decimal_ascii: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
design/sitda_pkg.sv
design/sitda_if.sv
design/sitda_div10.sv
design/signed_int_to_decimal_ascii.sv
tb/sv/signed_int_to_decimal_ascii_tb.sv
